// File: rtl/mtpc_pkg.sv
// shared types, constants and saturating helpers for the meson contraction block
// no dependencies; used by mtpc_datapath and meson_two_point_contraction
`default_nettype none

package mtpc_pkg;

  // lattice dimensions
  localparam int SPIN_DIM    = 4;
  localparam int COLOR_DIM   = 3;
  localparam int CC_SIZE     = COLOR_DIM * COLOR_DIM;
  localparam int STORE_DEPTH = SPIN_DIM * SPIN_DIM * CC_SIZE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // gamma register packing and reset (identity)
  localparam logic [15:0] GAMMA_RESET = 16'd228;
  localparam int PHASE_OFS = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_SINK      = 2'd0;
  localparam logic [1:0] CFG_SOURCE    = 2'd1;
  localparam logic [1:0] CFG_CHIRALITY = 2'd2;

  // input function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_STREAM = 1'b1;

  localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic       last;
    logic [1:0] phase;
  } ctl_t;

  // saturating 64-bit add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SAT_MIN : SAT_MAX;
    end
    return s[63:0];
  endfunction

  // saturating negate
  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    return (a == SAT_MIN) ? SAT_MAX : -a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mtpc_datapath.sv
// complex conj(f) * b product with saturating sums and i^p rotation, three stages
// depends on mtpc_pkg (ctl_t, sat_add, sat_neg)
`default_nettype none

module mtpc_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire mtpc_pkg::ctl_t       ctl_i,
  input  wire logic signed [31:0]   fr_i,
  input  wire logic signed [31:0]   fi_i,
  input  wire logic        [63:0]   b_i,
  output mtpc_pkg::ctl_t            ctl_o,
  output logic signed [63:0]        rot_re_o,
  output logic signed [63:0]        rot_im_o
);

  logic signed [31:0] br, bi;
  assign br = b_i[31:0];
  assign bi = b_i[63:32];

  // stage 2: four partial products
  mtpc_pkg::ctl_t     ctl2_q;
  logic signed [63:0] frbr_q, fibi_q, frbi_q, fibr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frbr_q <= 64'(fr_i) * 64'(br);
      fibi_q <= 64'(fi_i) * 64'(bi);
      frbi_q <= 64'(fr_i) * 64'(bi);
      fibr_q <= 64'(fi_i) * 64'(br);
    end
  end

  // stage 3: saturating real and imaginary sums
  mtpc_pkg::ctl_t     ctl3_q;
  logic signed [63:0] pr_q, pi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= mtpc_pkg::sat_add(frbr_q, fibi_q);
      pi_q <= mtpc_pkg::sat_add(frbi_q, mtpc_pkg::sat_neg(fibr_q));
    end
  end

  // stage 4: rotate by i to the power of the phase
  logic signed [63:0] rot_re_d, rot_im_d;

  always_comb begin
    case (ctl3_q.phase)
      2'd0: begin
        rot_re_d = pr_q;
        rot_im_d = pi_q;
      end
      2'd1: begin
        rot_re_d = mtpc_pkg::sat_neg(pi_q);
        rot_im_d = pr_q;
      end
      2'd2: begin
        rot_re_d = mtpc_pkg::sat_neg(pr_q);
        rot_im_d = mtpc_pkg::sat_neg(pi_q);
      end
      default: begin
        rot_re_d = pi_q;
        rot_im_d = mtpc_pkg::sat_neg(pr_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_re_o <= rot_re_d;
      rot_im_o <= rot_im_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/meson_two_point_contraction.sv
// meson two-point contraction: backward store, gamma index mapping, accumulate
// a forward entry with last set shows its trace after the stage 1, datapath and result registers
// throughput: one transaction per cycle, load or forward, while in_stall_o is low; the store
// read port and the product pipeline each take one entry per cycle while enabled
// reset: accumulator cleared, gammas set to identity, store contents undefined until loaded
`default_nettype none

module meson_two_point_contraction (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                func_i,
  input  wire logic        [1:0]   spin_row_i,
  input  wire logic        [1:0]   spin_col_i,
  input  wire logic        [3:0]   color_index_i,
  input  wire logic signed [31:0]  elem_re_i,
  input  wire logic signed [31:0]  elem_im_i,
  input  wire logic                last_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [63:0]       trace_re_o,
  output logic signed [63:0]       trace_im_o,
  // configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic        [1:0]   cfg_index_i,
  input  wire logic        [15:0]  cfg_data_i
);

  localparam int AW = mtpc_pkg::ADDR_W;

  function automatic logic [1:0] g_perm(input logic [15:0] g, input logic [1:0] k);
    return g[2*k +: 2];
  endfunction

  function automatic logic [1:0] g_phase(input logic [15:0] g, input logic [1:0] k);
    return g[mtpc_pkg::PHASE_OFS + 2*k +: 2];
  endfunction

  // configuration registers
  logic [15:0] snk_q, src_q, g5_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snk_q <= mtpc_pkg::GAMMA_RESET;
      src_q <= mtpc_pkg::GAMMA_RESET;
      g5_q  <= mtpc_pkg::GAMMA_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mtpc_pkg::CFG_SINK:      snk_q <= cfg_data_i;
        mtpc_pkg::CFG_SOURCE:    src_q <= cfg_data_i;
        mtpc_pkg::CFG_CHIRALITY: g5_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline enable: hold only when a trace is ready and the output is still occupied
  mtpc_pkg::ctl_t     ctl4;
  logic signed [63:0] rot_re, rot_im;
  logic               out_v_q, out_v_d;
  logic               en;

  assign en         = !(ctl4.valid && ctl4.last && out_v_q && out_stall_i);
  assign in_stall_o = !en;

  logic in_acc;
  assign in_acc = in_valid_i && en;

  // index mapping for the incoming entry
  logic [1:0]    c1, c2;
  logic          idx_ok, perm_ok;
  logic [AW-1:0] ld_addr, rd_addr;
  logic [1:0]    phase;

  always_comb begin
    c2 = g_perm(src_q, g_perm(g5_q, spin_row_i));
    c1 = g_perm(g5_q, g_perm(snk_q, spin_col_i));
    idx_ok = (int'(spin_row_i) < mtpc_pkg::SPIN_DIM) &&
             (int'(spin_col_i) < mtpc_pkg::SPIN_DIM) &&
             (int'(color_index_i) < mtpc_pkg::CC_SIZE);
    perm_ok = (int'(c1) < mtpc_pkg::SPIN_DIM) && (int'(c2) < mtpc_pkg::SPIN_DIM);
    ld_addr = (AW'(spin_row_i) * AW'(mtpc_pkg::SPIN_DIM) + AW'(spin_col_i))
              * AW'(mtpc_pkg::CC_SIZE) + AW'(color_index_i);
    rd_addr = (AW'(c2) * AW'(mtpc_pkg::SPIN_DIM) + AW'(c1))
              * AW'(mtpc_pkg::CC_SIZE) + AW'(color_index_i);
    if (!(idx_ok && perm_ok)) begin
      rd_addr = '0;
    end
    phase = g_phase(snk_q, spin_col_i) + g_phase(g5_q, c1) + g_phase(g5_q, c2)
            + g_phase(src_q, c2);
  end

  // backward store, one write and one registered read per cycle while the pipeline is enabled
  logic [63:0] store_mem [mtpc_pkg::STORE_DEPTH];
  logic [63:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == mtpc_pkg::FUNC_LOAD && idx_ok) begin
      store_mem[ld_addr] <= {elem_im_i, elem_re_i};
    end
    if (en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  // stage 1 control and forward operands, aligned with the read data
  mtpc_pkg::ctl_t     ctl1_q, ctl1_d;
  logic signed [31:0] fr_q, fi_q;

  always_comb begin
    ctl1_d.valid = in_valid_i && func_i == mtpc_pkg::FUNC_STREAM;
    ctl1_d.ok    = idx_ok && perm_ok;
    ctl1_d.last  = last_i;
    ctl1_d.phase = phase;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en) begin
      ctl1_q <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_q <= elem_re_i;
      fi_q <= elem_im_i;
    end
  end

  // product, sum and rotation stages
  mtpc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (ctl1_q),
    .fr_i     (fr_q),
    .fi_i     (fi_q),
    .b_i      (rd_data_q),
    .ctl_o    (ctl4),
    .rot_re_o (rot_re),
    .rot_im_o (rot_im)
  );

  // saturating accumulate and result register
  logic signed [63:0] acc_re_q, acc_im_q;
  logic signed [63:0] sum_re, sum_im;

  always_comb begin
    sum_re = acc_re_q;
    sum_im = acc_im_q;
    if (ctl4.ok) begin
      sum_re = mtpc_pkg::sat_add(acc_re_q, rot_re);
      sum_im = mtpc_pkg::sat_add(acc_im_q, rot_im);
    end
  end

  // result valid: kept while stalled, set by a closing entry
  always_comb begin
    out_v_d = out_v_q && out_stall_i;
    if (en && ctl4.valid && ctl4.last) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (en && ctl4.valid) begin
        if (ctl4.last) begin
          acc_re_q <= '0;
          acc_im_q <= '0;
        end else begin
          acc_re_q <= sum_re;
          acc_im_q <= sum_im;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && ctl4.valid && ctl4.last) begin
      trace_re_o <= sum_re;
      trace_im_o <= sum_im;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for meson_two_point_contraction: fills the backward store,
// streams forward entries under several gamma settings and checks every trace
// depends on mtpc_pkg and meson_two_point_contraction only

module testbench;

  localparam int CYCLE_LIMIT      = 150000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 10;

  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;

  // quarter turns of the product, powers of i
  typedef enum logic [1:0] {TURN_0, TURN_1, TURN_2, TURN_3} quarter_turn_e;

  // one propagator entry as it crosses the input channel
  typedef struct {
    logic              func;
    logic [1:0]        row;
    logic [1:0]        col;
    logic [3:0]        color;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic              last;
  } prop_entry_t;

  typedef struct {
    longint re;
    longint im;
  } trace_t;

  // contraction predictor and queue of traces still owed by the block
  class trace_scoreboard;
    logic signed [31:0] bwd_re [mtpc_pkg::STORE_DEPTH];
    logic signed [31:0] bwd_im [mtpc_pkg::STORE_DEPTH];
    longint      acc_re = 0;
    longint      acc_im = 0;
    logic [15:0] gamma [3] = '{mtpc_pkg::GAMMA_RESET, mtpc_pkg::GAMMA_RESET,
                               mtpc_pkg::GAMMA_RESET};
    trace_t      pending_traces [$];
    int          n_errors = 0;
    int          n_traces = 0;
    int          n_saturated = 0;
    int          n_loads = 0;
    int          n_forward = 0;

    function void set_gamma(logic [1:0] idx, logic [15:0] data);
      gamma[idx] = data;
    endfunction

    function longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        return a[63] ? mtpc_pkg::SAT_MIN : mtpc_pkg::SAT_MAX;
      end
      return s;
    endfunction

    function longint neg_sat(longint a);
      return (a == mtpc_pkg::SAT_MIN) ? mtpc_pkg::SAT_MAX : -a;
    endfunction

    function logic [1:0] perm_of(logic [15:0] g, logic [1:0] k);
      return g[2 * k +: 2];
    endfunction

    function logic [1:0] phase_of(logic [15:0] g, logic [1:0] k);
      return g[mtpc_pkg::PHASE_OFS + 2 * k +: 2];
    endfunction

    // fold one accepted entry into the store or the running trace
    function void note_entry(prop_entry_t e);
      int         addr;
      logic [1:0] c1;
      logic [1:0] c2;
      logic [1:0] turns;
      longint     fr, fi, br, bi, pr, pim, rr, ri;
      if (e.func == mtpc_pkg::FUNC_LOAD) begin
        n_loads++;
        if (e.color < mtpc_pkg::CC_SIZE) begin
          addr = (int'(e.row) * mtpc_pkg::SPIN_DIM + int'(e.col)) * mtpc_pkg::CC_SIZE
                 + int'(e.color);
          bwd_re[addr] = e.re;
          bwd_im[addr] = e.im;
        end
        return;
      end
      n_forward++;
      c2 = perm_of(gamma[mtpc_pkg::CFG_SOURCE], perm_of(gamma[mtpc_pkg::CFG_CHIRALITY], e.row));
      c1 = perm_of(gamma[mtpc_pkg::CFG_CHIRALITY], perm_of(gamma[mtpc_pkg::CFG_SINK], e.col));
      if (e.color < mtpc_pkg::CC_SIZE) begin
        addr = (int'(c2) * mtpc_pkg::SPIN_DIM + int'(c1)) * mtpc_pkg::CC_SIZE
               + int'(e.color);
        fr = e.re;
        fi = e.im;
        br = bwd_re[addr];
        bi = bwd_im[addr];
        // conj(forward) times backward, each part an exact sum then saturated
        pr  = add_sat(fr * br, fi * bi);
        pim = add_sat(fr * bi, neg_sat(fi * br));
        turns = phase_of(gamma[mtpc_pkg::CFG_SINK], e.col)
              + phase_of(gamma[mtpc_pkg::CFG_CHIRALITY], c1)
              + phase_of(gamma[mtpc_pkg::CFG_CHIRALITY], c2)
              + phase_of(gamma[mtpc_pkg::CFG_SOURCE], c2);
        case (turns)
          TURN_0: begin
            rr = pr;
            ri = pim;
          end
          TURN_1: begin
            rr = neg_sat(pim);
            ri = pr;
          end
          TURN_2: begin
            rr = neg_sat(pr);
            ri = neg_sat(pim);
          end
          default: begin
            rr = pim;
            ri = neg_sat(pr);
          end
        endcase
        acc_re = add_sat(acc_re, rr);
        acc_im = add_sat(acc_im, ri);
      end
      if (e.last) begin
        pending_traces.push_back('{re: acc_re, im: acc_im});
        acc_re = 0;
        acc_im = 0;
      end
    endfunction

    // compare a delivered trace with the oldest one owed
    function void check_trace(logic signed [63:0] re, logic signed [63:0] im);
      trace_t want;
      if (pending_traces.size() == 0) begin
        $error("unexpected trace: trace_re %0d trace_im %0d", re, im);
        n_errors++;
        return;
      end
      want = pending_traces.pop_front();
      n_traces++;
      if (want.re == mtpc_pkg::SAT_MAX || want.re == mtpc_pkg::SAT_MIN ||
          want.im == mtpc_pkg::SAT_MAX || want.im == mtpc_pkg::SAT_MIN) begin
        n_saturated++;
      end
      if (re !== want.re) begin
        $error("trace_re mismatch: expected %0d, actual %0d", want.re, re);
        n_errors++;
      end
      if (im !== want.im) begin
        $error("trace_im mismatch: expected %0d, actual %0d", want.im, im);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               func_i        = mtpc_pkg::FUNC_LOAD;
  logic [1:0]         spin_row_i    = '0;
  logic [1:0]         spin_col_i    = '0;
  logic [3:0]         color_index_i = '0;
  logic signed [31:0] elem_re_i     = '0;
  logic signed [31:0] elem_im_i     = '0;
  logic               last_i        = 1'b0;
  logic               out_stall_i   = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [1:0]         cfg_index_i   = mtpc_pkg::CFG_SINK;
  logic [15:0]        cfg_data_i    = mtpc_pkg::GAMMA_RESET;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [63:0] trace_re_o;
  logic signed [63:0] trace_im_o;
  logic               cfg_ready_o;

  trace_scoreboard sb;
  bit idle_enable  = 1'b1;
  bit stall_enable = 1'b1;
  bit hold_long    = 1'b0;
  int cycle_count  = 0;
  int n_sent       = 0;
  int n_settings   = 1;

  meson_two_point_contraction u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .spin_row_i    (spin_row_i),
    .spin_col_i    (spin_col_i),
    .color_index_i (color_index_i),
    .elem_re_i     (elem_re_i),
    .elem_im_i     (elem_im_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .trace_re_o    (trace_re_o),
    .trace_im_o    (trace_im_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout at cycle %0d, %0d traces outstanding", cycle_count,
             sb.pending_traces.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result transactions
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_trace(trace_re_o, trace_im_o);
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        if (stall_enable) repeat ($urandom_range(0, 7)) @(posedge clk_i);
      end
    end
  end

  function automatic prop_entry_t make_entry(logic func, logic [1:0] row, logic [1:0] col,
                                             logic [3:0] color, logic signed [31:0] re,
                                             logic signed [31:0] im, logic last);
    prop_entry_t e;
    e.func  = func;
    e.row   = row;
    e.col   = col;
    e.color = color;
    e.re    = re;
    e.im    = im;
    e.last  = last;
    return e;
  endfunction

  // narrow values lie between minus one and one, wide ones reach the extremes
  function automatic logic signed [31:0] rand_q724(bit wide);
    if (!wide) return $urandom_range(0, 32'h01FF_FFFF) - Q_ONE;
    case ($urandom_range(0, 9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3, 4:    return $urandom_range(0, 32'h01FF_FFFF) - Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  // mostly valid colour elements, now and then one past the end of the range
  function automatic logic [3:0] pick_color();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(mtpc_pkg::CC_SIZE, 15));
    return 4'($urandom_range(0, mtpc_pkg::CC_SIZE - 1));
  endfunction

  // gamma with a true permutation and random phases
  function automatic logic [15:0] perm_gamma();
    logic [1:0]  cols [4];
    logic [1:0]  t;
    int          pick;
    logic [15:0] g;
    cols = '{2'd0, 2'd1, 2'd2, 2'd3};
    for (int k = 3; k > 0; k--) begin
      pick = $urandom_range(0, k);
      t = cols[k];
      cols[k] = cols[pick];
      cols[pick] = t;
    end
    g = 16'($urandom) & 16'hFF00;
    for (int k = 0; k < 4; k++) g[2 * k +: 2] = cols[k];
    return g;
  endfunction

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_entry(input prop_entry_t e);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= e.func;
    spin_row_i    <= e.row;
    spin_col_i    <= e.col;
    color_index_i <= e.color;
    elem_re_i     <= e.re;
    elem_im_i     <= e.im;
    last_i        <= e.last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_entry(e);
    n_sent++;
  endtask

  // sender pause until every trace is back, then let loads finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_traces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write all three gamma registers, block idle
  task automatic apply_gammas(input logic [15:0] snk, input logic [15:0] src,
                              input logic [15:0] g5);
    logic [1:0]  idx [3];
    logic [15:0] vals [3];
    idx  = '{mtpc_pkg::CFG_SINK, mtpc_pkg::CFG_SOURCE, mtpc_pkg::CFG_CHIRALITY};
    vals = '{snk, src, g5};
    for (int k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_gamma(idx[k], vals[k]);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // every backward entry written before any forward read
  task automatic fill_backward();
    for (int r = 0; r < mtpc_pkg::SPIN_DIM; r++)
      for (int c = 0; c < mtpc_pkg::SPIN_DIM; c++)
        for (int k = 0; k < mtpc_pkg::CC_SIZE; k++)
          send_entry(make_entry(mtpc_pkg::FUNC_LOAD, 2'(r), 2'(c), 4'(k), rand_q724(1'b1),
                                rand_q724(1'b1), 1'($urandom)));
  endtask

  // forward sequence closed by last
  task automatic forward_run(input int len, input bit wide);
    for (int k = 0; k < len; k++)
      send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'($urandom), 2'($urandom), pick_color(),
                            rand_q724(wide), rand_q724(wide), k == len - 1));
  endtask

  // whole forward propagator in order, one trace at the end
  task automatic forward_sweep();
    int n;
    n = 0;
    for (int j = 0; j < mtpc_pkg::SPIN_DIM; j++)
      for (int i = 0; i < mtpc_pkg::SPIN_DIM; i++)
        for (int k = 0; k < mtpc_pkg::CC_SIZE; k++) begin
          n++;
          send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'(j), 2'(i), 4'(k), rand_q724(1'b0),
                                rand_q724(1'b0), n == mtpc_pkg::STORE_DEPTH));
        end
  endtask

  task automatic run_directed();
    // extreme backward entries, last ignored on a load
    send_entry(make_entry(mtpc_pkg::FUNC_LOAD, 2'd0, 2'd0, 4'd0, Q_MIN, Q_MIN, 1'b0));
    send_entry(make_entry(mtpc_pkg::FUNC_LOAD, 2'd3, 2'd3, 4'd8, Q_MAX, Q_MAX, 1'b1));
    send_entry(make_entry(mtpc_pkg::FUNC_LOAD, 2'd1, 2'd2, 4'd4, Q_MIN, Q_MAX, 1'b0));
    // colour past the end leaves the store alone
    send_entry(make_entry(mtpc_pkg::FUNC_LOAD, 2'd0, 2'd0, 4'd9, '0, '0, 1'b0));
    send_entry(make_entry(mtpc_pkg::FUNC_LOAD, 2'd3, 2'd3, 4'd15, '0, '0, 1'b1));
    // most negative squared, real part saturates high
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd0, 2'd0, 4'd0, Q_MIN, Q_MIN, 1'b1));
    // accumulator saturates high, then low
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd3, 2'd3, 4'd8, Q_MAX, Q_MAX, 1'b0));
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd3, 2'd3, 4'd8, Q_MAX, Q_MAX, 1'b0));
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd3, 2'd3, 4'd8, Q_MAX, Q_MAX, 1'b1));
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd3, 2'd3, 4'd8, Q_MIN, Q_MIN, 1'b0));
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd3, 2'd3, 4'd8, Q_MIN, Q_MIN, 1'b0));
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd3, 2'd3, 4'd8, Q_MIN, Q_MIN, 1'b1));
    // mixed signs
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd1, 2'd2, 4'd4, Q_MAX, Q_MIN, 1'b1));
    // colour past the end contributes nothing but still closes the trace
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd0, 2'd1, 4'd9, Q_MAX, Q_MAX, 1'b1));
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd2, 2'd1, 4'd12, Q_MIN, Q_MIN, 1'b0));
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd2, 2'd1, 4'd3, Q_ONE, '0, 1'b1));
    // zero entry
    send_entry(make_entry(mtpc_pkg::FUNC_STREAM, 2'd1, 2'd1, 4'd0, '0, '0, 1'b1));
  endtask

  // mostly closed forward sequences, some reloads and some noise
  task automatic run_random(input int n_items);
    int stop_at;
    int len;
    bit wide;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      wide = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++)
            send_entry(make_entry(mtpc_pkg::FUNC_LOAD, 2'($urandom), 2'($urandom),
                                  pick_color(), rand_q724(wide), rand_q724(wide),
                                  1'($urandom)));
        end
        2: begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++)
            send_entry(make_entry(1'($urandom), 2'($urandom), 2'($urandom), 4'($urandom),
                                  rand_q724(1'b1), rand_q724(1'b1), 1'($urandom)));
        end
        default: forward_run($urandom_range(1, 24), wide);
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gammas (identity)
    fill_backward();
    run_directed();
    run_random(150);
    settle();

    // all-zero and all-ones gamma words
    apply_gammas(16'h0000, 16'h0000, 16'h0000);
    run_random(120);
    settle();
    apply_gammas(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(120);
    settle();

    // arbitrary words; receiver holds off while traces keep coming
    apply_gammas(16'($urandom), 16'($urandom), 16'($urandom));
    idle_enable  = 1'b0;
    stall_enable = 1'b0;
    hold_long    = 1'b1;
    for (int k = 0; k < 40; k++) forward_run(1, 1'b0);
    idle_enable  = 1'b1;
    stall_enable = 1'b1;
    run_random(120);
    settle();

    // true gamma permutations with a full forward sweep
    apply_gammas(perm_gamma(), perm_gamma(), perm_gamma());
    forward_sweep();
    run_random(60);
    settle();

    // last part with no idling on either side
    idle_enable  = 1'b0;
    stall_enable = 1'b0;
    apply_gammas(perm_gamma(), mtpc_pkg::GAMMA_RESET, perm_gamma());
    run_random(150);
    settle();

    $display("covered %0d loads and %0d forward entries over %0d gamma settings",
             sb.n_loads, sb.n_forward, n_settings);
    $display("%0d traces checked, %0d saturated, %0d mismatches",
             sb.n_traces, sb.n_saturated, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_traces.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
